// File: rtl/core/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types and constants of the battery load protection block.
// ----------------------------------------------------------------------------
package blp_pkg;

    // event kinds
    localparam logic [1:0] FUNC_SLEEP  = 2'd0;
    localparam logic [1:0] FUNC_WAKE   = 2'd1;
    localparam logic [1:0] FUNC_MANUAL = 2'd2;

    // action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_OFF  = 2'd1;
    localparam logic [1:0] ACT_ON   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_OFF_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_ON_HYST       = 3'd1;
    localparam logic [2:0] CFG_MIN_OFF       = 3'd2;
    localparam logic [2:0] CFG_MAX_OFF       = 3'd3;
    localparam logic [2:0] CFG_PROT_EN       = 3'd4;
    localparam logic [2:0] CFG_CRIT_SLEEP    = 3'd5;
    localparam logic [2:0] CFG_MED_SLEEP     = 3'd6;
    localparam logic [2:0] CFG_HIGH_SLEEP    = 3'd7;

    // sleep lengths in seconds
    localparam logic [16:0] CRIT_SLEEP_SEC = 17'd3600;
    localparam logic [16:0] LOW_SLEEP_SEC  = 17'd1800;
    localparam logic [16:0] MED_SLEEP_SEC  = 17'd900;
    localparam logic [16:0] HIGH_SLEEP_SEC = 17'd300;

    // wake counter wraps to zero above this
    localparam logic [9:0] WAKE_LIMIT = 10'd1000;

    localparam logic [23:0] OFF_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [12:0] off_threshold_mv;
        logic [12:0] on_hysteresis_mv;
        logic [23:0] min_off_seconds;
        logic [23:0] max_off_seconds;
        logic        protection_enable;
        logic [12:0] critical_sleep_mv;
        logic [12:0] medium_sleep_mv;
        logic [12:0] high_sleep_mv;
    } blp_cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] battery_mv;
        logic        manual_on;
    } blp_item_t;

    typedef struct packed {
        logic [16:0] sleep_len;
        logic        load_on;
        logic        protection_active;
        logic [23:0] off_time_seconds;
        logic [9:0]  wake_number;
        logic [1:0]  action;
    } blp_result_t;

endpackage

// File: rtl/core/battery_load_protection.sv
// ----------------------------------------------------------------------------
// battery_load_protection
// Top level: input register, event logic and result register.
// ----------------------------------------------------------------------------
// Each event passes from the input register to the result register, and a new
// event is accepted every cycle as long as the result side keeps taking
// results; result valid rises once the result register has taken the event.
// The rate is set by the update of the load/protection state, which every
// event reads and writes. Configuration writes take effect on the next cycle
// and should be made while no event is in flight.
module battery_load_protection (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [12:0] s_battery_mv,
    input  logic        s_manual_on,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_sleep_len,
    output logic        m_load_on,
    output logic        m_protection_active,
    output logic [23:0] m_off_time_seconds,
    output logic [9:0]  m_wake_number,
    output logic [1:0]  m_action,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    blp_pkg::blp_cfg_t    cfg;
    blp_pkg::blp_item_t   in_item_reg;
    blp_pkg::blp_result_t result;
    blp_pkg::blp_result_t out_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;

    // event moves from input register to result register when the latter frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func       <= s_func;
            in_item_reg.battery_mv <= s_battery_mv;
            in_item_reg.manual_on  <= s_manual_on;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    blp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    blp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_valid             = out_valid_reg;
    assign m_sleep_len         = out_reg.sleep_len;
    assign m_load_on           = out_reg.load_on;
    assign m_protection_active = out_reg.protection_active;
    assign m_off_time_seconds  = out_reg.off_time_seconds;
    assign m_wake_number       = out_reg.wake_number;
    assign m_action            = out_reg.action;

endmodule

// File: rtl/core/blp_cfg.sv
// ----------------------------------------------------------------------------
// blp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module blp_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_wdata,
    output blp_pkg::blp_cfg_t cfg
);

    blp_pkg::blp_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_threshold_mv  <= 13'd3300;
            cfg_reg.on_hysteresis_mv  <= 13'd200;
            cfg_reg.min_off_seconds   <= 24'd3600;
            cfg_reg.max_off_seconds   <= 24'd86400;
            cfg_reg.protection_enable <= 1'b1;
            cfg_reg.critical_sleep_mv <= 13'd3200;
            cfg_reg.medium_sleep_mv   <= 13'd3600;
            cfg_reg.high_sleep_mv     <= 13'd3900;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                blp_pkg::CFG_OFF_THRESHOLD: cfg_reg.off_threshold_mv  <= cfg_wdata[12:0];
                blp_pkg::CFG_ON_HYST:       cfg_reg.on_hysteresis_mv  <= cfg_wdata[12:0];
                blp_pkg::CFG_MIN_OFF:       cfg_reg.min_off_seconds   <= cfg_wdata;
                blp_pkg::CFG_MAX_OFF:       cfg_reg.max_off_seconds   <= cfg_wdata;
                blp_pkg::CFG_PROT_EN:       cfg_reg.protection_enable <= cfg_wdata[0];
                blp_pkg::CFG_CRIT_SLEEP:    cfg_reg.critical_sleep_mv <= cfg_wdata[12:0];
                blp_pkg::CFG_MED_SLEEP:     cfg_reg.medium_sleep_mv   <= cfg_wdata[12:0];
                blp_pkg::CFG_HIGH_SLEEP:    cfg_reg.high_sleep_mv     <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/blp_ctrl.sv
// ----------------------------------------------------------------------------
// blp_ctrl
// Load/protection state and the single-pass decision logic for one event.
// ----------------------------------------------------------------------------
module blp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  blp_pkg::blp_item_t   item,
    input  blp_pkg::blp_cfg_t    cfg,
    output blp_pkg::blp_result_t result
);

    logic        load_reg,    load_next;
    logic        protect_reg, protect_next;
    logic [23:0] off_reg,     off_next;
    logic [16:0] last_reg,    last_next;
    logic [9:0]  wake_reg,    wake_next;

    logic        low;
    logic [16:0] sleep_sel;
    logic [10:0] wake_sum;
    logic [24:0] off_sum;
    logic [23:0] off_acc;
    logic [13:0] recover_th;
    logic        good;
    logic        min_ok;
    logic        max_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg    <= 1'b1;
            protect_reg <= 1'b0;
            off_reg     <= '0;
            last_reg    <= '0;
            wake_reg    <= '0;
        end else if (step) begin
            load_reg    <= load_next;
            protect_reg <= protect_next;
            off_reg     <= off_next;
            last_reg    <= last_next;
            wake_reg    <= wake_next;
        end
    end

    always_comb begin
        low = (item.battery_mv < cfg.off_threshold_mv) && cfg.protection_enable;

        priority if (item.battery_mv < cfg.critical_sleep_mv) begin
            sleep_sel = blp_pkg::CRIT_SLEEP_SEC;
        end else if (item.battery_mv < cfg.medium_sleep_mv) begin
            sleep_sel = blp_pkg::LOW_SLEEP_SEC;
        end else if (item.battery_mv < cfg.high_sleep_mv) begin
            sleep_sel = blp_pkg::MED_SLEEP_SEC;
        end else begin
            sleep_sel = blp_pkg::HIGH_SLEEP_SEC;
        end

        wake_sum = {1'b0, wake_reg} + 11'd1;

        // off time accumulates only inside a protection period, saturating
        off_sum = {1'b0, off_reg} + {8'd0, last_reg};
        if (!protect_reg) begin
            off_acc = off_reg;
        end else if (off_sum[24]) begin
            off_acc = blp_pkg::OFF_MAX;
        end else begin
            off_acc = off_sum[23:0];
        end

        recover_th = {1'b0, cfg.off_threshold_mv} + {1'b0, cfg.on_hysteresis_mv};
        good   = {1'b0, item.battery_mv} >= recover_th;
        min_ok = off_acc >= cfg.min_off_seconds;
        max_ok = off_acc >= cfg.max_off_seconds;

        load_next    = load_reg;
        protect_next = protect_reg;
        off_next     = off_reg;
        last_next    = last_reg;
        wake_next    = wake_reg;
        result.sleep_len = '0;

        unique case (item.func)
            blp_pkg::FUNC_SLEEP: begin
                wake_next = (wake_sum > {1'b0, blp_pkg::WAKE_LIMIT}) ? '0 : wake_sum[9:0];
                last_next = sleep_sel;
                result.sleep_len = sleep_sel;
                if (low) begin
                    load_next = 1'b0;
                    if (!protect_reg) begin
                        protect_next = 1'b1;
                        off_next     = '0;
                    end
                end
            end
            blp_pkg::FUNC_WAKE: begin
                off_next = off_acc;
                priority if (low) begin
                    if (load_reg) begin
                        load_next = 1'b0;
                        if (!protect_reg) begin
                            protect_next = 1'b1;
                            off_next     = '0;
                        end
                    end
                end else if (protect_reg && !load_reg) begin
                    if ((good && min_ok) || max_ok) begin
                        load_next    = 1'b1;
                        protect_next = 1'b0;
                        off_next     = '0;
                    end
                end else if ((item.battery_mv >= cfg.off_threshold_mv) && !load_reg) begin
                    load_next = 1'b1;
                end else begin
                end
            end
            blp_pkg::FUNC_MANUAL: begin
                load_next = item.manual_on;
            end
            default: ;
        endcase

        result.load_on           = load_next;
        result.protection_active = protect_next;
        result.off_time_seconds  = off_next;
        result.wake_number       = wake_next;
        if (load_reg && !load_next) begin
            result.action = blp_pkg::ACT_OFF;
        end else if (!load_reg && load_next) begin
            result.action = blp_pkg::ACT_ON;
        end else begin
            result.action = blp_pkg::ACT_NONE;
        end
    end

endmodule

// File: rtl/core/blp_checker.sv
// ----------------------------------------------------------------------------
// blp_checker
// Port-level checks of the battery load protection block, bound to the top.
// ----------------------------------------------------------------------------
module blp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [16:0] m_sleep_len,
    input logic        m_load_on,
    input logic        m_protection_active,
    input logic [23:0] m_off_time_seconds,
    input logic [9:0]  m_wake_number,
    input logic [1:0]  m_action
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sleep_len) && $stable(m_load_on)
            && $stable(m_off_time_seconds) && $stable(m_action))
        else $error("stalled result changed");

    // reported action agrees with the reported load state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == blp_pkg::ACT_OFF) |-> !m_load_on)
        else $error("load off action with load on");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == blp_pkg::ACT_ON) |-> m_load_on)
        else $error("load on action with load off");

    // off time only builds up inside a protection period
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_protection_active |-> m_off_time_seconds == '0)
        else $error("off time outside protection");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_wake_number <= blp_pkg::WAKE_LIMIT)
        else $error("wake counter above limit");

endmodule

bind battery_load_protection blp_checker u_blp_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_sleep_len         (m_sleep_len),
    .m_load_on           (m_load_on),
    .m_protection_active (m_protection_active),
    .m_off_time_seconds  (m_off_time_seconds),
    .m_wake_number       (m_wake_number),
    .m_action            (m_action)
);
